### hw/rtl/wsd_pkg.sv
// wsd_pkg: types and constants shared by the websocket deframer files
// no dependencies

package wsd_pkg;

    // parser phases
    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_DATA = 3'd4,
        PH_DROP = 3'd5
    } t_phase;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    // classified beat passed from parser to output stage
    typedef struct packed {
        t_kind      kind;
        logic [3:0] opcode;
        logic [7:0] raw;
        logic [7:0] key;
        logic       last;
    } t_tok;

    localparam logic [31:0] MAX_LEN_RESET = 32'd67108864;
    localparam logic [6:0]  LEN_CODE_16   = 7'd126;
    localparam logic [6:0]  LEN_CODE_64   = 7'd127;
    localparam logic [2:0]  EXT16_BYTES   = 3'd1;
    localparam logic [2:0]  EXT64_BYTES   = 3'd7;
    localparam logic [2:0]  MASK_BYTES    = 3'd3;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

endpackage

### hw/rtl/wsd_if.sv
// wsd_if: stream and configuration channel interfaces of the deframer
// depends on nothing; instantiated by the parent of websocket_frame_deframer

interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [3:0] frame_opcode;
    logic [7:0] data_byte;
    logic       last;
    modport source (output valid, output kind, output frame_opcode, output data_byte,
                    output last, input ready);
    modport sink   (input valid, input kind, input frame_opcode, input data_byte,
                    input last, output ready);
endinterface

interface wsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] max_payload_length;
    modport source (output valid, output max_payload_length, input ready);
    modport sink   (input valid, input max_payload_length, output ready);
endinterface

### hw/rtl/wsd_front.sv
// wsd_front: header parser, classifies each received byte and pushes result beats
// depends on wsd_pkg and wsd_if

module wsd_front
    import wsd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsd_in_if.sink      i_in,
    wsd_cfg_if.sink     i_cfg,
    input  logic        i_q_full,
    output logic        o_push,
    output t_tok        o_tok
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_opc, n_opc;
    logic        r_mask, n_mask;
    logic [2:0]  r_cnt, n_cnt;
    logic [63:0] r_len, n_len;
    logic [63:0] r_rem, n_rem;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_mpos, n_mpos;
    logic [31:0] r_max;

    logic        accept;
    logic [7:0]  b;
    logic        hd;
    logic [63:0] cand_len;
    logic        over;
    logic [4:0]  key_sh;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_q_full;
    assign accept      = i_in.valid && !i_q_full;
    assign b           = i_in.rx_byte;

    // limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_LEN_RESET;
        end else if (i_cfg.valid) begin
            r_max <= i_cfg.max_payload_length;
        end
    end

    // length check at end of header
    assign over   = (|cand_len[63:32]) || (cand_len[31:0] > r_max);
    assign key_sh = 5'd24 - {r_mpos, 3'd0};

    // next state and beat classification
    always_comb begin
        n_phase  = r_phase;
        n_opc    = r_opc;
        n_mask   = r_mask;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_rem    = r_rem;
        n_key    = r_key;
        n_mpos   = r_mpos;
        hd       = 1'b0;
        cand_len = r_len;
        o_push   = 1'b0;
        o_tok    = '{kind: KIND_PAYLOAD, opcode: r_opc, raw: 8'd0, key: 8'd0, last: 1'b0};
        if (accept) begin
            unique case (r_phase)
                PH_HDR1: begin
                    n_mask = b[7];
                    n_key  = '0;
                    n_len  = '0;
                    if (b[6:0] == LEN_CODE_16) begin
                        n_cnt   = EXT16_BYTES;
                        n_phase = PH_EXT;
                    end else if (b[6:0] == LEN_CODE_64) begin
                        n_cnt   = EXT64_BYTES;
                        n_phase = PH_EXT;
                    end else begin
                        n_len    = {57'd0, b[6:0]};
                        cand_len = n_len;
                        if (b[7]) begin
                            n_cnt   = MASK_BYTES;
                            n_phase = PH_MASK;
                        end else begin
                            hd = 1'b1;
                        end
                    end
                end
                PH_EXT: begin
                    n_len    = {r_len[55:0], b};
                    cand_len = n_len;
                    if (r_cnt == 3'd0) begin
                        if (r_mask) begin
                            n_cnt   = MASK_BYTES;
                            n_phase = PH_MASK;
                        end else begin
                            hd = 1'b1;
                        end
                    end else begin
                        n_cnt = r_cnt - 3'd1;
                    end
                end
                PH_MASK: begin
                    n_key = {r_key[23:0], b};
                    if (r_cnt == 3'd0) begin
                        hd = 1'b1;
                    end else begin
                        n_cnt = r_cnt - 3'd1;
                    end
                end
                PH_DATA: begin
                    n_mpos    = r_mpos + 2'd1;
                    n_rem     = r_rem - 64'd1;
                    o_push    = 1'b1;
                    o_tok.raw = b;
                    o_tok.key = r_key[key_sh +: 8];
                    if (r_rem == 64'd1) begin
                        o_tok.last = 1'b1;
                        n_phase    = PH_HDR0;
                    end
                end
                PH_DROP: begin
                end
                default: begin
                    n_opc   = b[3:0];
                    n_phase = PH_HDR1;
                end
            endcase
            // header finished
            if (hd) begin
                if (over) begin
                    n_phase    = PH_DROP;
                    o_push     = 1'b1;
                    o_tok.kind = KIND_ERROR;
                end else if (cand_len == 64'd0) begin
                    n_phase    = PH_HDR0;
                    o_push     = 1'b1;
                    o_tok.kind = KIND_EMPTY;
                    o_tok.last = 1'b1;
                end else begin
                    n_rem   = cand_len;
                    n_mpos  = 2'd0;
                    n_phase = PH_DATA;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR0;
            r_opc   <= '0;
            r_mask  <= 1'b0;
            r_cnt   <= '0;
            r_len   <= '0;
            r_rem   <= '0;
            r_key   <= '0;
            r_mpos  <= '0;
        end else begin
            r_phase <= n_phase;
            r_opc   <= n_opc;
            r_mask  <= n_mask;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_rem   <= n_rem;
            r_key   <= n_key;
            r_mpos  <= n_mpos;
        end
    end

    // an error beat locks the parser
    a_err_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_tok.kind == KIND_ERROR) |=> (r_phase == PH_DROP))
        else $error("error beat did not lock parser");

    // nothing leaves a locked parser
    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DROP) |-> !o_push)
        else $error("beat pushed while dropping");

    // a payload phase always has bytes left
    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_rem != 64'd0))
        else $error("payload phase with zero remaining");

endmodule

### hw/rtl/wsd_queue.sv
// wsd_queue: short beat queue between parser and output stage
// depends on wsd_pkg

module wsd_queue
    import wsd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_tok  i_tok,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_tok  o_tok
);

    t_tok           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QCW-1:0] r_count;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            r_count <= r_count + QCW'(i_push) - QCW'(i_pop);
        end
    end

    // no overflow or underflow
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full) && !(i_pop && !o_valid))
        else $error("queue overflow or underflow");

endmodule

### hw/rtl/wsd_back.sv
// wsd_back: unmasks queued beats into the output register
// depends on wsd_pkg and wsd_if

module wsd_back
    import wsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_tok      i_q_tok,
    output logic      o_pop,
    wsd_out_if.source o_out
);

    logic       r_valid;
    t_kind      r_kind;
    logic [3:0] r_opc;
    logic [7:0] r_data;
    logic       r_last;

    assign o_pop = i_q_valid && (!r_valid || o_out.ready);

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || o_out.ready) begin
            r_valid <= i_q_valid;
        end
    end

    // output payload, xor with mask byte
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_q_tok.kind;
            r_opc  <= i_q_tok.opcode;
            r_data <= i_q_tok.raw ^ i_q_tok.key;
            r_last <= i_q_tok.last;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.kind         = r_kind;
    assign o_out.frame_opcode = r_opc;
    assign o_out.data_byte    = r_data;
    assign o_out.last         = r_last;

    // non-payload beats carry zero data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind != KIND_PAYLOAD) |-> (r_data == 8'd0))
        else $error("non-payload beat with data");

endmodule

### hw/rtl/websocket_frame_deframer.sv
// websocket_frame_deframer: top level, parser -> beat queue -> output stage
// depends on wsd_pkg, wsd_if, wsd_front, wsd_queue, wsd_back
//
//  channel  dir  signals                                           beat
//  i_in     in   valid ready rx_byte[7:0]                          one received byte
//  o_out    out  valid ready kind[1:0] frame_opcode[3:0]
//                data_byte[7:0] last                               one result
//  i_cfg    in   valid ready max_payload_length[31:0]              limit write
//
// one byte accepted per cycle while the queue is not full; a result passes from the
// combinational parser into a queue entry, then into the output register
// i_in.ready drops only when the four-entry queue is full under output stall
// i_cfg.ready is always high; synchronous active-low reset, no clearing pass
// after a length error all input bytes are taken and dropped until reset

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    wsd_in_if.sink    i_in,
    wsd_cfg_if.sink   i_cfg,
    wsd_out_if.source o_out
);

    logic q_full, q_push, q_valid, q_pop;
    t_tok push_tok, head_tok;

    wsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_q_full(q_full),
        .o_push  (q_push),
        .o_tok   (push_tok)
    );

    wsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_tok   (push_tok),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_tok   (head_tok)
    );

    wsd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_tok  (head_tok),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

endmodule

### dv/websocket_frame_deframer_tb.sv
// websocket_frame_deframer_tb: self-checking bench for the websocket frame deframer
// drives byte beats through wsd_in_if, limit writes through wsd_cfg_if, checks wsd_out_if
// depends on wsd_pkg, wsd_if and websocket_frame_deframer
`timescale 1ns / 1ps

module websocket_frame_deframer_tb
    import wsd_pkg::*;
();

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int SHOW_FAILS     = 10;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] op;
        logic [7:0] data;
        logic       last;
    } frame_res_t;

    // one byte to send, optionally with its result pinned by hand
    typedef struct {
        logic [7:0] b;
        bit         pinned;
        bit         has_res;
        frame_res_t res;
    } byte_tag_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wsd_in_if  in_if();
    wsd_cfg_if cfg_if();
    wsd_out_if out_if();

    websocket_frame_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // shared bench state
    frame_res_t  due_results[$];
    byte_tag_t   tags_in_flight[$];
    int          snd_gap_pct   = 0;
    int          rcv_stall_pct = 0;
    bit          hold_req      = 1'b0;
    logic [31:0] cur_limit     = MAX_LEN_RESET;
    int          fail_cnt      = 0;
    int          n_sent        = 0;
    int          n_bytes_in    = 0;
    int          n_res_seen    = 0;
    int          n_payload     = 0;
    int          n_empty       = 0;
    int          n_err         = 0;
    int          n_frames      = 0;
    int          quiet_cycles  = 0;

    // deframer shadow state, reset values
    t_phase      pr_phase  = PH_HDR0;
    logic [3:0]  pr_op     = '0;
    logic        pr_masked = 1'b0;
    logic [2:0]  pr_cnt    = '0;
    logic [63:0] pr_len    = '0;
    logic [63:0] pr_left   = '0;
    logic [31:0] pr_key    = '0;
    logic [1:0]  pr_kpos   = '0;
    logic [31:0] lim_shadow = MAX_LEN_RESET;

    function automatic byte_tag_t gives(input logic [7:0] b, input t_kind k,
                                        input logic [3:0] op, input logic [7:0] d,
                                        input logic lst);
        byte_tag_t t;
        t.b        = b;
        t.pinned   = 1'b1;
        t.has_res  = 1'b1;
        t.res.kind = k;
        t.res.op   = op;
        t.res.data = d;
        t.res.last = lst;
        return t;
    endfunction

    function automatic byte_tag_t silent(input logic [7:0] b);
        byte_tag_t t;
        t = gives(b, KIND_PAYLOAD, 4'h0, 8'h00, 1'b0);
        t.has_res = 1'b0;
        return t;
    endfunction

    function automatic byte_tag_t predicted(input logic [7:0] b);
        byte_tag_t t;
        t = silent(b);
        t.pinned = 1'b0;
        return t;
    endfunction

    function automatic void note_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= SHOW_FAILS) $display("%s", msg);
    endfunction

    // header fully read: limit test, empty frame, or start of payload
    task automatic close_header(output bit got, output frame_res_t r);
        if (pr_len > {32'h0, lim_shadow}) begin
            pr_phase = PH_DROP;
            got = 1'b1;
            r = '{KIND_ERROR, pr_op, 8'h00, 1'b0};
        end else if (pr_len == 64'd0) begin
            pr_phase = PH_HDR0;
            got = 1'b1;
            r = '{KIND_EMPTY, pr_op, 8'h00, 1'b1};
        end else begin
            pr_left  = pr_len;
            pr_kpos  = '0;
            pr_phase = PH_DATA;
        end
    endtask

    task automatic length_known(output bit got, output frame_res_t r);
        if (pr_masked) begin
            pr_cnt   = MASK_BYTES;
            pr_phase = PH_MASK;
        end else begin
            close_header(got, r);
        end
    endtask

    // advance the shadow parser by one received byte
    task automatic parse_byte(input logic [7:0] b, output bit got, output frame_res_t r);
        logic [7:0] kb;
        got = 1'b0;
        r   = '{KIND_PAYLOAD, 4'h0, 8'h00, 1'b0};
        case (pr_phase)
            PH_HDR1: begin
                pr_masked = b[7];
                pr_key    = '0;
                pr_len    = '0;
                if (b[6:0] == LEN_CODE_16) begin
                    pr_cnt   = EXT16_BYTES;
                    pr_phase = PH_EXT;
                end else if (b[6:0] == LEN_CODE_64) begin
                    pr_cnt   = EXT64_BYTES;
                    pr_phase = PH_EXT;
                end else begin
                    pr_len = {57'h0, b[6:0]};
                    length_known(got, r);
                end
            end
            PH_EXT: begin
                pr_len = {pr_len[55:0], b};
                if (pr_cnt == 3'd0) length_known(got, r);
                else pr_cnt = pr_cnt - 3'd1;
            end
            PH_MASK: begin
                pr_key = {pr_key[23:0], b};
                if (pr_cnt == 3'd0) close_header(got, r);
                else pr_cnt = pr_cnt - 3'd1;
            end
            PH_DATA: begin
                kb      = pr_key[8 * (3 - int'(pr_kpos)) +: 8];
                pr_kpos = pr_kpos + 2'd1;
                pr_left = pr_left - 64'd1;
                got     = 1'b1;
                r       = '{KIND_PAYLOAD, pr_op, b ^ kb, pr_left == 64'd0};
                if (pr_left == 64'd0) pr_phase = PH_HDR0;
            end
            PH_DROP: begin
            end
            default: begin
                pr_op    = b[3:0];
                pr_phase = PH_HDR1;
            end
        endcase
    endtask

    // scoreboard: predict on input beats, compare on output beats
    always @(posedge i_clk) begin : score
        byte_tag_t  tg;
        frame_res_t pr;
        frame_res_t w;
        bit         hit;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) lim_shadow = cfg_if.max_payload_length;
            if (in_if.valid && in_if.ready) begin
                n_bytes_in++;
                tg = tags_in_flight.pop_front();
                parse_byte(in_if.rx_byte, hit, pr);
                if (tg.pinned) begin
                    if (tg.has_res) due_results.insert(due_results.size(), tg.res);
                end else if (hit) begin
                    due_results.insert(due_results.size(), pr);
                end
            end
            if (out_if.valid && out_if.ready) begin
                n_res_seen++;
                case (out_if.kind)
                    KIND_PAYLOAD: n_payload++;
                    KIND_EMPTY:   n_empty++;
                    default:      n_err++;
                endcase
                if (due_results.size() == 0) begin
                    note_fail($sformatf("unexpected result: kind %0d op %h data %h last %b",
                        out_if.kind, out_if.frame_opcode, out_if.data_byte, out_if.last));
                end else begin
                    w = due_results.pop_front();
                    if (out_if.kind !== w.kind || out_if.frame_opcode !== w.op ||
                        out_if.data_byte !== w.data || out_if.last !== w.last)
                        note_fail($sformatf({"result %0d mismatch: want kind %0d op %h data %h",
                            " last %b, got kind %0d op %h data %h last %b"}, n_res_seen,
                            w.kind, w.op, w.data, w.last, out_if.kind, out_if.frame_opcode,
                            out_if.data_byte, out_if.last));
                end
            end
        end
    end

    // watchdog on beat progress
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, due_results.size());
            $display("websocket_frame_deframer verification failed");
            $finish;
        end
    end

    // result side: random stalls, or one long hold when asked
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    // one byte beat; valid stays up when the next beat follows directly
    task automatic send_byte(input byte_tag_t t);
        while (snd_gap_pct != 0 && $urandom_range(99) < snd_gap_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        tags_in_flight.insert(tags_in_flight.size(), t);
        in_if.valid   <= 1'b1;
        in_if.rx_byte <= t.b;
        n_sent++;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    // let every expected result come out, then let header-only bytes settle
    task automatic wait_drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] v);
        cfg_if.valid              <= 1'b1;
        cfg_if.max_payload_length <= v;
        cur_limit = v;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // well-formed frame, random header bits, length within the current limit
    task automatic send_random_frame();
        int unsigned cap_small;
        int unsigned cap_big;
        int unsigned r;
        int unsigned len;
        int unsigned form;
        logic [63:0] len64;
        logic        msk;
        cap_small = (cur_limit < 32'd20) ? cur_limit : 20;
        cap_big   = (cur_limit < 32'd300) ? cur_limit : 300;
        r = $urandom_range(99);
        if (r < 6) len = 0;
        else if (r < 10) len = cap_big;
        else if (r < 16) len = $urandom_range(cap_big);
        else len = $urandom_range(cap_small);
        len64 = 64'(len);
        if (len > 125) form = $urandom_range(1, 2);
        else begin
            r = $urandom_range(99);
            form = (r < 80) ? 0 : (r < 90) ? 1 : 2;
        end
        msk = 1'($urandom_range(1));
        n_frames++;
        send_byte(predicted(8'($urandom_range(255))));
        case (form)
            0: send_byte(predicted({msk, len64[6:0]}));
            1: begin
                send_byte(predicted({msk, LEN_CODE_16}));
                send_byte(predicted(len64[15:8]));
                send_byte(predicted(len64[7:0]));
            end
            default: begin
                send_byte(predicted({msk, LEN_CODE_64}));
                for (int i = 7; i >= 0; i--) send_byte(predicted(len64[8 * i +: 8]));
            end
        endcase
        if (msk) repeat (4) send_byte(predicted(8'($urandom_range(255))));
        repeat (len) send_byte(predicted(8'($urandom_range(255))));
    endtask

    task automatic run_phase(input logic [31:0] lim, input int gap, input int stall,
                             input int budget, input bit with_hold);
        int target;
        write_limit(lim);
        snd_gap_pct   = gap;
        rcv_stall_pct = stall;
        if (with_hold) hold_req = 1'b1;
        target = n_sent + budget;
        while (n_sent < target) send_random_frame();
        wait_drain();
    endtask

    // main sequence
    initial begin
        byte_tag_t dir_tbl[$];
        byte_tag_t tail_tbl[$];

        in_if.valid               <= 1'b0;
        in_if.rx_byte             <= 8'h00;
        cfg_if.valid              <= 1'b0;
        cfg_if.max_payload_length <= 32'h0;
        i_rst_n                   <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_tbl = '{
            // empty text frame, unmasked
            silent(8'h81), gives(8'h00, KIND_EMPTY, 4'h1, 8'h00, 1'b1),
            // reserved opcode with rsv bits, one unmasked byte passes through
            silent(8'h7F), silent(8'h01), gives(8'hFF, KIND_PAYLOAD, 4'hF, 8'hFF, 1'b1),
            // non-minimal 16-bit length, masked, key position wraps
            silent(8'h02), silent(8'hFE), silent(8'h00), silent(8'h05),
            silent(8'hFF), silent(8'h00), silent(8'hA5), silent(8'h5A),
            predicted(8'h00), predicted(8'hFF), predicted(8'h00), predicted(8'h5A),
            predicted(8'h33),
            // masked zero-length ping: result after the last key byte
            silent(8'h89), silent(8'h80), silent(8'h01), silent(8'h02), silent(8'h03),
            gives(8'h04, KIND_EMPTY, 4'h9, 8'h00, 1'b1)
        };
        foreach (dir_tbl[i]) send_byte(dir_tbl[i]);
        wait_drain();

        // random phases: limit, sender gap %, receiver stall %, bytes, long hold
        run_phase(32'hFFFF_FFFF, 0, 0, 450, 1'b1);
        run_phase(32'd0, 88, 0, 150, 1'b0);
        run_phase(32'd37, 0, 88, 400, 1'b0);
        run_phase(32'd1000, 36, 36, 600, 1'b0);

        // a length error locks the parser until reset, so it closes the run
        write_limit(32'hFFFF_FFFF);
        snd_gap_pct   = 36;
        rcv_stall_pct = 36;
        tail_tbl = '{
            silent(8'h0A), silent(8'hFF),
            silent(8'h80), silent(8'h00), silent(8'h00), silent(8'h00),
            silent(8'hFF), silent(8'hFF), silent(8'hFF), silent(8'hFF),
            silent(8'h11), silent(8'h22), silent(8'h33),
            gives(8'h44, KIND_ERROR, 4'hA, 8'h00, 1'b0)
        };
        foreach (tail_tbl[i]) send_byte(tail_tbl[i]);
        // everything after the error is swallowed
        repeat (24) send_byte(predicted(8'($urandom_range(255))));
        wait_drain();

        while (due_results.size() != 0) begin
            void'(due_results.pop_front());
            note_fail("expected result never arrived");
        end

        $display("covered %0d bytes in %0d random frames plus directed; %0d results checked",
                 n_bytes_in, n_frames, n_res_seen);
        $display("  %0d payload, %0d empty, %0d error; limits reset/max/0/37/1000; %0d fails",
                 n_payload, n_empty, n_err, fail_cnt);
        if (fail_cnt == 0) begin
            $display("websocket_frame_deframer verification clean");
        end else begin
            $display("websocket_frame_deframer verification failed");
        end
        $finish;
    end

endmodule
